FILE: rtl/core/dpe_pkg.sv
// ----------------------------------------------------------------------------
// dpe_pkg
// Shared constants and types for the dose penalty evaluator.
// ----------------------------------------------------------------------------
package dpe_pkg;
    localparam int MaxOrgans   = 4;
    localparam int MaxVoxels   = 4096;
    localparam int MaxBeamlets = 1024;
    localparam int OrgW   = 2;
    localparam int VoxW   = 12;
    localparam int AddrW  = OrgW + VoxW;
    localparam int Depth  = MaxOrgans * MaxVoxels;

    localparam logic [2:0] FUNC_CLEAR   = 3'd0;
    localparam logic [2:0] FUNC_DEPOSIT = 3'd1;
    localparam logic [2:0] FUNC_LIMITS  = 3'd2;
    localparam logic [2:0] FUNC_EVAL    = 3'd3;
    localparam logic [2:0] FUNC_BEAM    = 3'd4;

    typedef struct packed {
        logic [2:0]  func;
        logic [1:0]  organ;
        logic [11:0] voxel;
        logic [15:0] deposition;
        logic [15:0] intensity;
        logic [9:0]  beamlet;
        logic        last;
        logic [15:0] weight;
        logic [31:0] dose_min;
        logic [31:0] dose_max;
        logic [12:0] voxel_count;
    } t_in;

    typedef struct packed {
        logic        kind;
        logic [63:0] total_penalty;
        logic        worst_found;
        logic [1:0]  worst_organ;
        logic [11:0] peak_voxel;
        logic        beamlet_found;
        logic [9:0]  top_beamlet;
    } t_out;

    // memory port request from the sequencer
    typedef struct packed {
        logic             rd;
        logic [AddrW-1:0] raddr;
        logic             we;
        logic [AddrW-1:0] waddr;
        logic [31:0]      wdata;
        logic             xwe;
        logic [AddrW-1:0] xaddr;
        logic             xdata;
    } t_mem_req;
endpackage

FILE: rtl/core/dpe_if.sv
// ----------------------------------------------------------------------------
// dpe_in_if / dpe_out_if
// Valid/ready channels carrying input and result transactions.
// ----------------------------------------------------------------------------
interface dpe_in_if import dpe_pkg::*; ();
    logic valid;
    logic ready;
    t_in  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dpe_out_if import dpe_pkg::*; ();
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/dpe_store.sv
// ----------------------------------------------------------------------------
// dpe_store
// Dose memory and excluded map, registered reads.
// ----------------------------------------------------------------------------
module dpe_store import dpe_pkg::*; (
    input  logic        i_clk,
    input  t_mem_req    i_req,
    output logic [31:0] o_dose,
    output logic        o_excl
);
    logic [31:0] r_dose_mem [Depth];
    logic        r_excl_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_req.we) r_dose_mem[i_req.waddr] <= i_req.wdata;
        if (i_req.rd) o_dose <= r_dose_mem[i_req.raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.xwe) r_excl_mem[i_req.xaddr] <= i_req.xdata;
        if (i_req.rd) o_excl <= r_excl_mem[i_req.raddr];
    end
endmodule

FILE: rtl/core/dpe_core.sv
// ----------------------------------------------------------------------------
// dpe_core
// Sequencer: clear sweep, deposit read-modify-write, evaluation walk,
// beamlet search and organ limits.
// ----------------------------------------------------------------------------
module dpe_core import dpe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata,
    dpe_in_if.sink      in_ch,
    dpe_out_if.source   out_ch,
    output t_mem_req    o_req,
    input  logic [31:0] i_dose,
    input  logic        i_excl
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CLR   = 7'b0000010,
        S_DRD   = 7'b0000100,
        S_DWR   = 7'b0001000,
        S_EVAL  = 7'b0010000,
        S_EDRN  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    t_in    r_item;
    logic [2:0]  r_in_use;
    logic [15:0] r_wt  [MaxOrgans];
    logic [31:0] r_min [MaxOrgans];
    logic [31:0] r_max [MaxOrgans];
    logic [12:0] r_cnt [MaxOrgans];
    logic [15:0] r_sbv;
    logic [9:0]  r_sbi;
    logic        r_sf;
    logic [AddrW:0] r_clr;
    logic        r_init;
    logic [31:0] r_prod;

    // walk address and pipeline
    logic [OrgW:0]  r_wo;
    logic [VoxW:0]  r_wk;
    logic           r_v1, r_v2, r_v3;
    logic [OrgW-1:0] r_o1, r_o2, r_o3;
    logic [VoxW-1:0] r_k1, r_k2, r_k3;
    logic [31:0] r_exc;
    logic [15:0] r_w2, r_w3;
    logic        r_x2, r_x3;
    logic [63:0] r_sq;
    logic [63:0] r_pen;
    logic [63:0] r_tot, r_best;
    logic        r_found;
    logic [OrgW-1:0] r_wor;
    logic [VoxW-1:0] r_wvx;
    t_out        r_out;
    logic        r_ovalid;

    logic [2:0]  walk;
    logic        take;
    logic        cand_hit;
    logic [OrgW-1:0] wo_i;
    logic        walk_end;
    logic [64:0] tsum;
    logic [47:0] ph, pl;

    assign walk = (r_in_use > 3'(MaxOrgans)) ? 3'(MaxOrgans) : r_in_use;
    assign in_ch.ready = (r_state == S_IDLE) && !r_ovalid;
    assign take = in_ch.valid && in_ch.ready;
    assign cand_hit = ({1'b0, in_ch.data.beamlet} < 11'(MaxBeamlets)) &&
                      (in_ch.data.deposition > r_sbv);
    assign wo_i = r_wo[OrgW-1:0];
    assign walk_end = (r_wo >= (OrgW+1)'(walk));
    assign out_ch.valid = r_ovalid;
    assign out_ch.data  = r_out;

    always_comb begin
        n_state = r_state;
        o_req = '0;
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    unique case (in_ch.data.func)
                        FUNC_CLEAR:   n_state = S_CLR;
                        FUNC_DEPOSIT: begin
                            if (in_ch.data.intensity != '0) begin
                                n_state = S_DRD;
                                o_req.rd = 1'b1;
                                o_req.raddr = {in_ch.data.organ, in_ch.data.voxel};
                            end
                        end
                        FUNC_EVAL:    n_state = S_EVAL;
                        default:      n_state = S_IDLE;
                    endcase
                end
            end
            S_CLR: begin
                o_req.we = 1'b1;
                o_req.waddr = r_clr[AddrW-1:0];
                if (r_init) begin
                    o_req.xwe = 1'b1;
                    o_req.xaddr = r_clr[AddrW-1:0];
                end
                if (r_clr[AddrW-1:0] == AddrW'(Depth - 1)) n_state = S_IDLE;
            end
            S_DRD: n_state = S_DWR;
            S_DWR: begin
                o_req.we = 1'b1;
                o_req.waddr = {r_item.organ, r_item.voxel};
                o_req.wdata = ({1'b0, i_dose} + {1'b0, r_prod} > 33'hFFFFFFFF) ?
                    32'hFFFFFFFF : i_dose + r_prod;
                n_state = S_IDLE;
            end
            S_EVAL: begin
                if (walk_end) n_state = S_EDRN;
                else if (r_wk < r_cnt[wo_i]) begin
                    o_req.rd = 1'b1;
                    o_req.raddr = {wo_i, r_wk[VoxW-1:0]};
                end
            end
            S_EDRN: if (!r_v1 && !r_v2 && !r_v3) n_state = S_OUT;
            S_OUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        if (take && in_ch.data.func == FUNC_BEAM && in_ch.data.last && !r_sf &&
            !cand_hit) begin
            o_req.xwe = 1'b1;
            o_req.xaddr = {in_ch.data.organ, in_ch.data.voxel};
            o_req.xdata = 1'b1;
        end
    end

    assign tsum = {1'b0, r_tot} + {1'b0, r_pen};
    assign ph = r_sq[63:32] * r_w3;
    assign pl = r_sq[31:0] * r_w3;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= in_ch.data;
            r_prod <= in_ch.data.deposition * in_ch.data.intensity;
        end

        // stage 1 read issued -> stage 2 compute excess
        r_v1 <= (r_state == S_EVAL) && o_req.rd;
        r_o1 <= wo_i;
        r_k1 <= r_wk[VoxW-1:0];
        r_v2 <= r_v1;
        r_o2 <= r_o1;
        r_k2 <= r_k1;
        r_x2 <= i_excl;
        r_w2 <= r_wt[r_o1];
        if (i_dose > r_max[r_o1])      r_exc <= i_dose - r_max[r_o1];
        else if (i_dose < r_min[r_o1]) r_exc <= r_min[r_o1] - i_dose;
        else                           r_exc <= '0;
        r_sq <= r_exc * r_exc;
        r_w3 <= r_w2;
        r_v3 <= r_v2;
        r_o3 <= r_o2;
        r_k3 <= r_k2;
        r_x3 <= r_x2;
        r_pen <= {8'h00, ph, 8'h00} + {40'h0, pl[47:24]};
    end

    logic r_v4;
    logic [OrgW-1:0] r_o4;
    logic [VoxW-1:0] r_k4;
    logic r_x4;
    always_ff @(posedge i_clk) begin
        r_v4 <= r_v3;
        r_o4 <= r_o3;
        r_k4 <= r_k3;
        r_x4 <= r_x3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr <= '0;
            r_init <= 1'b1;
            r_in_use <= 3'd1;
            r_sbv <= '0;
            r_sbi <= '0;
            r_sf <= 1'b0;
            r_ovalid <= 1'b0;
            r_wo <= '0;
            r_wk <= '0;
            for (int i = 0; i < MaxOrgans; i++) begin
                r_wt[i] <= '0;
                r_min[i] <= '0;
                r_max[i] <= '1;
                r_cnt[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_clr <= (r_state == S_CLR) ? r_clr + 1'b1 : '0;
            if (r_state == S_CLR && r_clr[AddrW-1:0] == AddrW'(Depth - 1)) r_init <= 1'b0;
            if (i_cfg_we) r_in_use <= i_cfg_wdata;
            if (out_ch.valid && out_ch.ready) r_ovalid <= 1'b0;
            if (take && in_ch.data.func == FUNC_LIMITS) begin
                r_wt[in_ch.data.organ]  <= in_ch.data.weight;
                r_min[in_ch.data.organ] <= in_ch.data.dose_min;
                r_max[in_ch.data.organ] <= in_ch.data.dose_max;
                r_cnt[in_ch.data.organ] <= (in_ch.data.voxel_count > 13'(MaxVoxels)) ?
                    13'(MaxVoxels) : in_ch.data.voxel_count;
            end
            if (take && in_ch.data.func == FUNC_BEAM) begin
                if (in_ch.data.last) begin
                    r_sbv <= '0;
                    r_sbi <= '0;
                    r_sf <= 1'b0;
                    r_ovalid <= 1'b1;
                    r_out <= {1'b1, 64'd0, 1'b0, 2'd0, 12'd0, cand_hit | r_sf,
                              cand_hit ? in_ch.data.beamlet : (r_sf ? r_sbi : 10'd0)};
                end else if (cand_hit) begin
                    r_sbv <= in_ch.data.deposition;
                    r_sbi <= in_ch.data.beamlet;
                    r_sf <= 1'b1;
                end
            end
            if (take && in_ch.data.func == FUNC_EVAL) begin
                r_wo <= '0;
                r_wk <= '0;
                r_tot <= '0;
                r_best <= '0;
                r_found <= 1'b0;
                r_wor <= '0;
                r_wvx <= '0;
            end
            if (r_state == S_EVAL && !walk_end) begin
                if (r_wk + 1'b1 >= {1'b0, r_cnt[wo_i]} || r_wk >= {1'b0, r_cnt[wo_i]}) begin
                    r_wk <= '0;
                    r_wo <= r_wo + 1'b1;
                end else begin
                    r_wk <= r_wk + 1'b1;
                end
            end
            if (r_v4) begin
                r_tot <= tsum[64] ? '1 : tsum[63:0];
                if (r_pen > r_best && !r_x4) begin
                    r_best <= r_pen;
                    r_found <= 1'b1;
                    r_wor <= r_o4;
                    r_wvx <= r_k4;
                end
            end
            if (r_state == S_OUT) begin
                r_ovalid <= 1'b1;
                r_out <= {1'b0, r_tot, r_found, r_wor, r_wvx, 1'b0, 10'd0};
            end
        end
    end
endmodule

FILE: rtl/core/dose_penalty_evaluator.sv
// ----------------------------------------------------------------------------
// dose_penalty_evaluator
// Dose store with deposit, limit load, penalty evaluation and beamlet search.
// ----------------------------------------------------------------------------
// One transaction at a time. After reset the dose memory and the excluded map
// are swept to zero, one entry a cycle, before the first transaction is taken.
// Limits and beamlet candidates are registered as they are taken, a deposit
// reads, modifies and writes the dose memory (no access at zero intensity), a
// clear sweeps the dose memory only, one entry a cycle, and an evaluation walks
// the voxels of the organs in use (an organ with no voxels still takes a walk
// step) through the single read port of the dose memory into the penalty
// pipeline. A result is
// held in an output register; no new transaction is taken while it waits.
module dose_penalty_evaluator import dpe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_wdata,
    dpe_in_if.sink     in_ch,
    dpe_out_if.source  out_ch
);
    t_mem_req    req;
    logic [31:0] dose;
    logic        excl;

    dpe_store u_store (
        .i_clk  (i_clk),
        .i_req  (req),
        .o_dose (dose),
        .o_excl (excl)
    );

    dpe_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .o_req       (req),
        .i_dose      (dose),
        .i_excl      (excl)
    );
endmodule

FILE: rtl/core/dpe_checker.sv
// ----------------------------------------------------------------------------
// dpe_checker
// Port-level checks on the evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module dpe_checker import dpe_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input t_in  in_data,
    input logic out_valid,
    input logic out_ready,
    input t_out out_data
);
    a_no_take_while_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready) else $error("input taken while result waits");
    a_beam_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_data.kind |-> out_data.total_penalty == '0 && !out_data.worst_found)
        else $error("beamlet result carries penalty fields");
    a_eval_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_data.kind |-> !out_data.beamlet_found)
        else $error("evaluation result carries beamlet fields");
    a_beam_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready && in_data.func == FUNC_BEAM && in_data.last |=> out_valid)
        else $error("missing beamlet result");
endmodule

bind dose_penalty_evaluator dpe_checker u_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_data   (in_ch.data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);

FILE: verif/dose_penalty_evaluator_test.sv
// ----------------------------------------------------------------------------
// dose_penalty_evaluator_test
// Drives deposit, limit, evaluate, clear and beamlet-search transactions into
// the evaluator with random idling on both channels. A cycle-free predictor
// mirrors the dose store, exclusion map, organ limits and search state, and
// every result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dose_penalty_evaluator_test;
    import dpe_pkg::*;

    localparam int DrainCycles = 16500;
    localparam int WatchdogLimit = 100000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_wdata = '0;

    dpe_in_if in_ch ();
    dpe_out_if out_ch ();

    dose_penalty_evaluator uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [31:0] dose_mem [Depth];
    logic        excl_mem [Depth];
    logic [15:0] lim_weight [MaxOrgans];
    logic [31:0] lim_min [MaxOrgans];
    logic [31:0] lim_max [MaxOrgans];
    logic [12:0] lim_count [MaxOrgans];
    logic [15:0] srch_val;
    logic [9:0]  srch_idx;
    logic        srch_hit;
    logic [2:0]  walk_organs;

    t_out pending_results [$];
    int errors = 0;
    int items_sent = 0;
    int results_checked = 0;
    int evals_sent = 0;
    int searches_done = 0;
    bit no_idle = 1'b0;
    int quiet_cycles = 0;

    function automatic logic [63:0] voxel_penalty(logic [63:0] excess, logic [15:0] w);
        logic [63:0] sq;
        logic [63:0] hi;
        logic [63:0] lo;
        sq = excess * excess;
        hi = (sq >> 32) * {48'd0, w};
        lo = (sq & 64'hFFFF_FFFF) * {48'd0, w};
        return (hi << 8) + (lo >> 24);
    endfunction

    task automatic apply_item(input t_in it);
        logic [AddrW-1:0] idx;
        logic [63:0] sum;
        logic [64:0] acc;
        logic [63:0] total;
        logic [63:0] best;
        logic [63:0] pen;
        logic [31:0] z;
        int walk;
        t_out res;
        idx = {it.organ, it.voxel};
        res = '0;
        case (it.func)
            FUNC_CLEAR: begin
                for (int i = 0; i < Depth; i++) dose_mem[i] = '0;
            end
            FUNC_DEPOSIT: begin
                if (it.intensity != 0) begin
                    sum = {32'd0, dose_mem[idx]} + 64'(it.deposition) * 64'(it.intensity);
                    dose_mem[idx] = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
                end
            end
            FUNC_LIMITS: begin
                lim_weight[it.organ] = it.weight;
                lim_min[it.organ] = it.dose_min;
                lim_max[it.organ] = it.dose_max;
                lim_count[it.organ] = (it.voxel_count > MaxVoxels) ? 13'(MaxVoxels)
                                                                  : it.voxel_count;
            end
            FUNC_EVAL: begin
                walk = (walk_organs > MaxOrgans) ? MaxOrgans : walk_organs;
                total = '0;
                best = '0;
                for (int o = 0; o < walk; o++) begin
                    for (int k = 0; k < lim_count[o]; k++) begin
                        idx = {o[1:0], k[11:0]};
                        z = dose_mem[idx];
                        pen = '0;
                        if (z < lim_min[o]) pen = voxel_penalty(64'(lim_min[o] - z), lim_weight[o]);
                        if (z > lim_max[o]) pen = voxel_penalty(64'(z - lim_max[o]), lim_weight[o]);
                        acc = {1'b0, total} + {1'b0, pen};
                        total = acc[64] ? '1 : acc[63:0];
                        if (pen > best && !excl_mem[idx]) begin
                            best = pen;
                            res.worst_found = 1'b1;
                            res.worst_organ = o[1:0];
                            res.peak_voxel = k[11:0];
                        end
                    end
                end
                res.total_penalty = total;
                pending_results.push_back(res);
                evals_sent++;
            end
            FUNC_BEAM: begin
                if (it.deposition > srch_val) begin
                    srch_val = it.deposition;
                    srch_idx = it.beamlet;
                    srch_hit = 1'b1;
                end
                if (it.last) begin
                    res.kind = 1'b1;
                    res.beamlet_found = srch_hit;
                    res.top_beamlet = srch_hit ? srch_idx : '0;
                    if (!srch_hit) excl_mem[{it.organ, it.voxel}] = 1'b1;
                    srch_val = '0;
                    srch_idx = '0;
                    srch_hit = 1'b0;
                    pending_results.push_back(res);
                    searches_done++;
                end
            end
            default: ;
        endcase
    endtask

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 18);
    endfunction

    // returns at a falling edge; valid stays high when the next gap is zero
    task automatic send_item(input t_in it);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        apply_item(it);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic go_idle();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        wait (pending_results.size() == 0);
        @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
    endtask

    task automatic set_organs_in_use(input logic [2:0] v);
        go_idle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        walk_organs = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_in noise_item();
        t_in it;
        it.func = 3'($urandom);
        it.organ = 2'($urandom);
        it.voxel = 12'($urandom);
        it.deposition = 16'($urandom);
        it.intensity = 16'($urandom);
        it.beamlet = 10'($urandom);
        it.last = 1'($urandom);
        it.weight = 16'($urandom);
        it.dose_min = $urandom;
        it.dose_max = $urandom;
        it.voxel_count = 13'($urandom);
        return it;
    endfunction

    function automatic t_in make_item(input logic [2:0] f);
        t_in it;
        it = noise_item();
        it.func = f;
        if (f == FUNC_BEAM) it.last = 1'b0;
        return it;
    endfunction

    task automatic send_limits(input logic [1:0] org, input logic [15:0] w,
                               input logic [31:0] lo, input logic [31:0] hi,
                               input logic [12:0] cnt);
        t_in it;
        it = make_item(FUNC_LIMITS);
        it.organ = org;
        it.weight = w;
        it.dose_min = lo;
        it.dose_max = hi;
        it.voxel_count = cnt;
        send_item(it);
    endtask

    task automatic send_deposit(input logic [1:0] org, input logic [11:0] vox,
                                input logic [15:0] dep, input logic [15:0] inten);
        t_in it;
        it = make_item(FUNC_DEPOSIT);
        it.organ = org;
        it.voxel = vox;
        it.deposition = dep;
        it.intensity = inten;
        send_item(it);
    endtask

    task automatic send_search(input int n, input bit all_zero, input logic [1:0] org,
                               input logic [11:0] vox);
        t_in it;
        for (int i = 0; i < n; i++) begin
            it = make_item(FUNC_BEAM);
            if (all_zero) it.deposition = '0;
            else if ($urandom_range(0, 3) == 0) it.deposition = 16'($urandom_range(0, 3));
            it.last = (i == n - 1);
            it.organ = org;
            it.voxel = vox;
            send_item(it);
        end
    endtask

    task automatic test_directed();
        t_in it;
        set_organs_in_use(3'd1);
        // all voxels below minimum with equal penalties, enough to saturate the total
        send_limits(2'd0, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 13'd300);
        send_item(make_item(FUNC_EVAL));
        // zero intensity skipped, deposit saturation, min above max
        send_limits(2'd0, 16'h0100, 32'h0010_0000, 32'h0000_1000, 13'd4);
        send_deposit(2'd0, 12'd0, 16'hFFFF, 16'h0000);
        send_deposit(2'd0, 12'd1, 16'hFFFF, 16'hFFFF);
        send_deposit(2'd0, 12'd1, 16'hFFFF, 16'hFFFF);
        send_deposit(2'd0, 12'd2, 16'h0008, 16'h0100);
        send_item(make_item(FUNC_EVAL));
        // failed search excludes the worst voxel, then a search with a winner
        send_search(3, 1'b1, 2'd0, 12'd1);
        send_search(1, 1'b0, 2'd3, 12'd4095);
        it = make_item(FUNC_BEAM);
        it.deposition = 16'hFFFF;
        it.beamlet = 10'd1023;
        it.last = 1'b1;
        send_item(it);
        send_item(make_item(FUNC_EVAL));
        for (int f = 5; f < 8; f++) send_item(make_item(3'(f)));
        // organs 3 and 1 at and near full size, count above the maximum saturates
        send_limits(2'd3, 16'h0001, 32'h0000_0000, 32'h0000_0000, 13'h1FFF);
        send_limits(2'd1, 16'h8000, 32'h0000_0001, 32'hFFFF_FFFF, 13'd4095);
        send_deposit(2'd3, 12'd4095, 16'h0001, 16'h0001);
        set_organs_in_use(3'd7);
        send_item(make_item(FUNC_EVAL));
        send_item(make_item(FUNC_CLEAR));
        send_item(make_item(FUNC_EVAL));
        send_limits(2'd1, 16'h0000, 32'h0, 32'h0, 13'd0);
        send_limits(2'd3, 16'h0000, 32'h0, 32'h0, 13'd0);
    endtask

    task automatic test_random(input int n);
        int r;
        int sent;
        int len;
        t_in it;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 39) == 0) no_idle = ~no_idle;
            r = $urandom_range(0, 99);
            if (r < 45) begin
                it = make_item(FUNC_DEPOSIT);
                if ($urandom_range(0, 9) != 0) it.voxel = 12'($urandom_range(0, 47));
                if ($urandom_range(0, 9) == 0) it.intensity = '0;
                else if ($urandom_range(0, 1)) it.intensity = 16'($urandom_range(0, 16'h0400));
                send_item(it);
                sent++;
            end else if (r < 55) begin
                it = make_item(FUNC_LIMITS);
                it.voxel_count = ($urandom_range(0, 29) == 0) ? 13'($urandom_range(0, 8191))
                                                              : 13'($urandom_range(0, 48));
                send_item(it);
                sent++;
            end else if (r < 67) begin
                send_item(make_item(FUNC_EVAL));
                sent++;
            end else if (r < 94) begin
                len = $urandom_range(1, 6);
                send_search(len, $urandom_range(0, 2) == 0, 2'($urandom),
                            12'($urandom_range(0, 47)));
                sent += len;
            end else if (r < 95) begin
                send_item(make_item(FUNC_CLEAR));
                sent++;
            end else begin
                send_item(make_item(3'($urandom_range(5, 7))));
            end
        end
        no_idle = 1'b0;
    endtask

    task automatic test_config_sweep();
        logic [2:0] settings [6] = '{3'd0, 3'd4, 3'd2, 3'd7, 3'd3, 3'd1};
        foreach (settings[i]) begin
            set_organs_in_use(settings[i]);
            test_random(130);
        end
    endtask

    // result sink
    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    initial begin
        int stall;
        t_out want;
        t_out got;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            got = out_ch.data;
            if (pending_results.size() == 0) begin
                $error("result with no prediction waiting");
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("kind", want.kind, got.kind);
                check_field("total_penalty", want.total_penalty, got.total_penalty);
                check_field("worst_found", want.worst_found, got.worst_found);
                check_field("worst_organ", want.worst_organ, got.worst_organ);
                check_field("peak_voxel", want.peak_voxel, got.peak_voxel);
                check_field("beamlet_found", want.beamlet_found, got.beamlet_found);
                check_field("top_beamlet", want.top_beamlet, got.top_beamlet);
            end
            results_checked++;
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (i_rst_n) begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WatchdogLimit) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        for (int i = 0; i < Depth; i++) begin
            dose_mem[i] = '0;
            excl_mem[i] = 1'b0;
        end
        for (int o = 0; o < MaxOrgans; o++) begin
            lim_weight[o] = '0;
            lim_min[o] = '0;
            lim_max[o] = '1;
            lim_count[o] = '0;
        end
        srch_val = '0;
        srch_idx = '0;
        srch_hit = 1'b0;
        walk_organs = 3'd1;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_config_sweep();
        go_idle();
        if (pending_results.size() != 0) begin
            $error("%0d predicted results never arrived", pending_results.size());
            errors++;
        end
        $display("Covered %0d transactions: %0d evaluations, %0d beamlet searches,",
                 items_sent, evals_sent, searches_done);
        $display("%0d results checked over several organ-in-use settings.", results_checked);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
